[hw/rtl/linear_mip_chain_layout_core_defines.svh]
// assertion macros for the mip chain layout core
// included by the rtl file that carries concurrent checks
`ifndef LINEAR_MIP_CHAIN_LAYOUT_CORE_DEFINES_SVH
`define LINEAR_MIP_CHAIN_LAYOUT_CORE_DEFINES_SVH

// same-cycle implication check
`define LMCL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lmcl check failed: same-cycle implication");

// next-cycle implication check
`define LMCL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lmcl check failed: next-cycle implication");

`endif

[hw/rtl/lmcl_pkg.sv]
// shared types, codes and helper functions for the mip chain layout core
// no dependencies; used by lmcl_entry, lmcl_cell and the top level
`default_nettype none

package lmcl_pkg;

   // fixed field widths of the request and response
   localparam int IMG_DIM_W   = 16;
   localparam int LVL_W       = 4;
   localparam int FMT_W       = 3;
   localparam int OFFSET_W    = 27;
   localparam int PITCH_OUT_W = 15;
   localparam int DIM_OUT_W   = 13;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 96;
   localparam int SAT_IN_W    = 40;

   localparam logic [SAT_IN_W-1:0] OFFSET_MAX = SAT_IN_W'((64'd1 << OFFSET_W) - 64'd1);
   localparam logic [SAT_IN_W-1:0] PITCH_MAX  = SAT_IN_W'((64'd1 << PITCH_OUT_W) - 64'd1);
   localparam logic [SAT_IN_W-1:0] DIM_MAX    = SAT_IN_W'((64'd1 << DIM_OUT_W) - 64'd1);

   // reciprocal used to split the base width by the stride alignment
   localparam int RECIP_SHIFT = 24;
   localparam int RECIP_W     = 25;

   // color format codes
   localparam logic [FMT_W-1:0] FMT_COLOR  = 3'd0;
   localparam logic [FMT_W-1:0] FMT_UNORM8 = 3'd1;
   localparam logic [FMT_W-1:0] FMT_UINT16 = 3'd2;
   localparam logic [FMT_W-1:0] FMT_UINT32 = 3'd3;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_BAD_SIZE   = 2'd1,
      STATUS_BAD_FORMAT = 2'd2
   } status_type;

   typedef struct packed {
      status_type                  status;
      logic [OFFSET_W-1:0]         level_offset;
      logic [PITCH_OUT_W-1:0]      level_pitch;
      logic [DIM_OUT_W-1:0]        tex_width;
      logic [DIM_OUT_W-1:0]        tex_height;
      logic [OFFSET_W-1:0]         run_total;
      logic                        last;
   } result_type;

   // internal width helpers, all evaluated at elaboration
   function automatic int dim_w(input int max_dim);
      return $clog2(max_dim + 1);
   endfunction

   function automatic int sw_w(input int max_dim, input int align);
      return $clog2((max_dim > align) ? max_dim : align) + 1;
   endfunction

   function automatic int sh_w(input int max_dim);
      return $clog2(max_dim) + 1;
   endfunction

   function automatic int shl_w(input int max_dim);
      return $clog2(sh_w(max_dim));
   endfunction

   function automatic int sha_w(input int max_dim);
      return $clog2(sh_w(max_dim) + 2);
   endfunction

   function automatic int rem_w(input int align);
      return (align > 1) ? $clog2(align) : 1;
   endfunction

   function automatic int pitch_w(input int max_dim);
      return ((dim_w(max_dim) + 10) > 16) ? (dim_w(max_dim) + 10) : 16;
   endfunction

   function automatic int tot_w(input int max_dim, input int align);
      return ((sw_w(max_dim, align) + sh_w(max_dim) + 5) > 28) ?
             (sw_w(max_dim, align) + sh_w(max_dim) + 5) : 28;
   endfunction

   // bytes per pixel as a shift amount
   function automatic logic [1:0] bpp_shift(input logic [FMT_W-1:0] fmt);
      logic [1:0] s;
      case (fmt)
         FMT_COLOR:  s = 2'd2;
         FMT_UNORM8: s = 2'd0;
         FMT_UINT16: s = 2'd1;
         FMT_UINT32: s = 2'd2;
         default:    s = 2'd0;
      endcase
      return s;
   endfunction

   function automatic logic fmt_supported(input logic [FMT_W-1:0] fmt);
      logic ok;
      case (fmt)
         FMT_COLOR, FMT_UNORM8, FMT_UINT16, FMT_UINT32: ok = 1'b1;
         default: ok = 1'b0;
      endcase
      return ok;
   endfunction

   // exponent of the next power of two at or above v (v >= 1)
   function automatic logic [4:0] log2_ceil16(input logic [IMG_DIM_W-1:0] v);
      logic [IMG_DIM_W-1:0] m;
      logic [4:0]           n;
      m = v - 16'd1;
      m = m | (m >> 1);
      m = m | (m >> 2);
      m = m | (m >> 4);
      m = m | (m >> 8);
      n = 5'd0;
      for (int i = 0; i < IMG_DIM_W; i++) begin
         if (m[i]) begin
            n = 5'(i + 1);
         end
      end
      return n;
   endfunction

   // clamp to the output field ranges
   function automatic logic [OFFSET_W-1:0] sat_size(input logic [SAT_IN_W-1:0] v);
      return (v > OFFSET_MAX) ? OFFSET_MAX[OFFSET_W-1:0] : v[OFFSET_W-1:0];
   endfunction

   function automatic logic [PITCH_OUT_W-1:0] sat_pitch(input logic [SAT_IN_W-1:0] v);
      return (v > PITCH_MAX) ? PITCH_MAX[PITCH_OUT_W-1:0] : v[PITCH_OUT_W-1:0];
   endfunction

   function automatic logic [DIM_OUT_W-1:0] sat_dim(input logic [SAT_IN_W-1:0] v);
      return (v > DIM_MAX) ? DIM_MAX[DIM_OUT_W-1:0] : v[DIM_OUT_W-1:0];
   endfunction

endpackage

`default_nettype wire

[hw/rtl/linear_mip_chain_layout_core.sv]
// mip chain layout core: entry stage, a row of MAX_LEVELS level cells, output register
// a request passes the entry register, the first cell and the output register; an error
// result goes straight to the output register. throughput: one level result per cycle
// while rsp_tready is high; the next request waits until the entry stage and every
// cell are empty
// reset: synchronous, active high, clears all valid flags; nothing else to clear
`default_nettype none

`include "linear_mip_chain_layout_core_defines.svh"

module linear_mip_chain_layout_core #(
   parameter int MAX_DIM      = 4096,
   parameter int MAX_LEVELS   = 13,
   parameter int STRIDE_ALIGN = 8
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // image_width, image_height, level_count, format_code, zero pad
   input  wire logic [lmcl_pkg::REQ_DATA_W-1:0]    req_tdata,
   // response
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // level_offset, level_pitch, texel width, texel height, running byte total, zero pad
   output logic [lmcl_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   // status
   output logic [1:0]                              rsp_tuser,
   output logic                                    rsp_tlast
);

   localparam int DIM_W = lmcl_pkg::dim_w(MAX_DIM);
   localparam int SW_W  = lmcl_pkg::sw_w(MAX_DIM, STRIDE_ALIGN);
   localparam int SHL_W = lmcl_pkg::shl_w(MAX_DIM);
   localparam int R_W   = lmcl_pkg::rem_w(STRIDE_ALIGN);
   localparam int TOT_W = lmcl_pkg::tot_w(MAX_DIM, STRIDE_ALIGN);

   logic                            adv, busy, req_fire, err_load, ent_load;
   lmcl_pkg::status_type            chk_status;

   logic                            ent_valid;
   logic [DIM_W-1:0]                ent_w, ent_h, ent_q;
   logic [R_W-1:0]                  ent_r;
   logic [SW_W-1:0]                 ent_sw;
   logic [SHL_W-1:0]                ent_shl;
   logic [1:0]                      ent_bpp;
   logic [lmcl_pkg::LVL_W-1:0]      ent_lvl;

   logic [MAX_LEVELS-1:0]           cell_valid, pass_valid, ld_valid;
   logic [DIM_W-1:0]                ld_w [MAX_LEVELS];
   logic [DIM_W-1:0]                ld_h [MAX_LEVELS];
   logic [DIM_W-1:0]                ld_q [MAX_LEVELS];
   logic [R_W-1:0]                  ld_r [MAX_LEVELS];
   logic [SW_W-1:0]                 ld_sw [MAX_LEVELS];
   logic [SHL_W-1:0]                ld_shl [MAX_LEVELS];
   logic [1:0]                      ld_bpp [MAX_LEVELS];
   logic [lmcl_pkg::LVL_W-1:0]      ld_lvl [MAX_LEVELS];
   logic [TOT_W-1:0]                ld_total [MAX_LEVELS];
   logic [DIM_W-1:0]                nx_w [MAX_LEVELS];
   logic [DIM_W-1:0]                nx_h [MAX_LEVELS];
   logic [DIM_W-1:0]                nx_q [MAX_LEVELS];
   logic [R_W-1:0]                  nx_r [MAX_LEVELS];
   logic [SW_W-1:0]                 nx_sw [MAX_LEVELS];
   logic [SHL_W-1:0]                nx_shl [MAX_LEVELS];
   logic [1:0]                      nx_bpp [MAX_LEVELS];
   logic [lmcl_pkg::LVL_W-1:0]      nx_lvl [MAX_LEVELS];
   logic [TOT_W-1:0]                nx_total [MAX_LEVELS];
   lmcl_pkg::result_type            cell_res [MAX_LEVELS];
   lmcl_pkg::result_type            chain_res, err_res;

   logic                            rsp_valid_ff, rsp_valid_in;
   lmcl_pkg::result_type            rsp_ff, rsp_in;
   logic                            rsp_load;

   // handshake control: one request in the chain at a time
   assign adv        = !rsp_valid_ff || rsp_tready;
   assign busy       = ent_valid || (|cell_valid);
   assign req_tready = !busy && adv;
   assign req_fire   = req_tvalid && req_tready;
   assign err_load   = req_fire && (chk_status != lmcl_pkg::STATUS_OK);
   assign ent_load   = req_fire && (chk_status == lmcl_pkg::STATUS_OK);

   lmcl_entry #(
      .MAX_DIM      (MAX_DIM),
      .MAX_LEVELS   (MAX_LEVELS),
      .STRIDE_ALIGN (STRIDE_ALIGN)
   ) u_entry (
      .clock        (clock),
      .reset        (reset),
      .image_width  (req_tdata[15:0]),
      .image_height (req_tdata[31:16]),
      .level_count  (req_tdata[35:32]),
      .format_code  (req_tdata[38:36]),
      .load         (ent_load),
      .chk_status   (chk_status),
      .valid        (ent_valid),
      .w_out        (ent_w),
      .h_out        (ent_h),
      .q_out        (ent_q),
      .r_out        (ent_r),
      .sw_out       (ent_sw),
      .shl_out      (ent_shl),
      .bpp_out      (ent_bpp),
      .lvl_out      (ent_lvl)
   );

   // cell inputs: the head takes the entry stage, the rest their left neighbor
   always_comb begin
      ld_valid[0] = ent_valid;
      ld_w[0]     = ent_w;
      ld_h[0]     = ent_h;
      ld_q[0]     = ent_q;
      ld_r[0]     = ent_r;
      ld_sw[0]    = ent_sw;
      ld_shl[0]   = ent_shl;
      ld_bpp[0]   = ent_bpp;
      ld_lvl[0]   = ent_lvl;
      ld_total[0] = '0;
      for (int i = 1; i < MAX_LEVELS; i++) begin
         ld_valid[i] = pass_valid[i-1];
         ld_w[i]     = nx_w[i-1];
         ld_h[i]     = nx_h[i-1];
         ld_q[i]     = nx_q[i-1];
         ld_r[i]     = nx_r[i-1];
         ld_sw[i]    = nx_sw[i-1];
         ld_shl[i]   = nx_shl[i-1];
         ld_bpp[i]   = nx_bpp[i-1];
         ld_lvl[i]   = nx_lvl[i-1];
         ld_total[i] = nx_total[i-1];
      end
   end

   for (genvar gi = 0; gi < MAX_LEVELS; gi++) begin : g_cell
      lmcl_cell #(
         .CELL_INDEX   (gi),
         .MAX_DIM      (MAX_DIM),
         .STRIDE_ALIGN (STRIDE_ALIGN)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .adv        (adv),
         .load       (ld_valid[gi]),
         .w_load     (ld_w[gi]),
         .h_load     (ld_h[gi]),
         .q_load     (ld_q[gi]),
         .r_load     (ld_r[gi]),
         .sw_load    (ld_sw[gi]),
         .shl_load   (ld_shl[gi]),
         .bpp_load   (ld_bpp[gi]),
         .lvl_load   (ld_lvl[gi]),
         .total_load (ld_total[gi]),
         .valid      (cell_valid[gi]),
         .pass_valid (pass_valid[gi]),
         .w_next     (nx_w[gi]),
         .h_next     (nx_h[gi]),
         .q_next     (nx_q[gi]),
         .r_next     (nx_r[gi]),
         .sw_next    (nx_sw[gi]),
         .shl_next   (nx_shl[gi]),
         .bpp_next   (nx_bpp[gi]),
         .lvl_next   (nx_lvl[gi]),
         .total_next (nx_total[gi]),
         .result     (cell_res[gi])
      );
   end

   // at most one cell holds the token, so an or of the gated results selects it
   always_comb begin
      chain_res = '0;
      for (int i = 0; i < MAX_LEVELS; i++) begin
         chain_res = chain_res | cell_res[i];
      end
   end

   // single error result for a rejected request
   always_comb begin
      err_res        = '0;
      err_res.status = chk_status;
      err_res.last   = 1'b1;
   end

   // output register
   assign rsp_load = err_load || ((|cell_valid) && adv);

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      rsp_in = err_load ? err_res : chain_res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff.run_total, rsp_ff.tex_height, rsp_ff.tex_width,
                        rsp_ff.level_pitch, rsp_ff.level_offset};
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tlast  = rsp_ff.last;

   // checks
   `LMCL_ASSERT_NOW(a_one_token, clock, reset, 1'b1, $onehot0(cell_valid))
   `LMCL_ASSERT_NOW(a_entry_alone, clock, reset, ent_valid, cell_valid == '0)
   `LMCL_ASSERT_NEXT(a_req_lands, clock, reset, req_fire, ent_valid || rsp_valid_ff)
   `LMCL_ASSERT_NEXT(a_stall_holds, clock, reset, (|cell_valid) && !adv, $stable(cell_valid))

endmodule

`default_nettype wire

[hw/rtl/lmcl_entry.sv]
// request entry stage: range checks, power-of-two storage size, width split
// into stride-aligned quotient and remainder; depends on lmcl_pkg
`default_nettype none

module lmcl_entry #(
   parameter int MAX_DIM      = 4096,
   parameter int MAX_LEVELS   = 13,
   parameter int STRIDE_ALIGN = 8,
   localparam int DIM_W = lmcl_pkg::dim_w(MAX_DIM),
   localparam int SW_W  = lmcl_pkg::sw_w(MAX_DIM, STRIDE_ALIGN),
   localparam int SHL_W = lmcl_pkg::shl_w(MAX_DIM),
   localparam int R_W   = lmcl_pkg::rem_w(STRIDE_ALIGN)
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic [lmcl_pkg::IMG_DIM_W-1:0]     image_width,
   input  wire logic [lmcl_pkg::IMG_DIM_W-1:0]     image_height,
   input  wire logic [lmcl_pkg::LVL_W-1:0]         level_count,
   input  wire logic [lmcl_pkg::FMT_W-1:0]         format_code,
   input  wire logic                               load,
   output lmcl_pkg::status_type                    chk_status,
   output logic                                    valid,
   output logic [DIM_W-1:0]                        w_out,
   output logic [DIM_W-1:0]                        h_out,
   output logic [DIM_W-1:0]                        q_out,
   output logic [R_W-1:0]                          r_out,
   output logic [SW_W-1:0]                         sw_out,
   output logic [SHL_W-1:0]                        shl_out,
   output logic [1:0]                              bpp_out,
   output logic [lmcl_pkg::LVL_W-1:0]              lvl_out
);

   localparam int PROD_W = DIM_W + lmcl_pkg::RECIP_W;
   localparam logic [lmcl_pkg::RECIP_W-1:0] RECIP =
      lmcl_pkg::RECIP_W'(((64'd1 << lmcl_pkg::RECIP_SHIFT) + 64'(STRIDE_ALIGN) - 64'd1)
                         / 64'(STRIDE_ALIGN));

   logic                               valid_ff, valid_in;
   logic [DIM_W-1:0]                   w_ff, h_ff, q_ff;
   logic [SW_W-1:0]                    sw_ff;
   logic [SHL_W-1:0]                   shl_ff;
   logic [1:0]                         bpp_ff;
   logic [lmcl_pkg::LVL_W-1:0]         lvl_ff;
   logic [PROD_W-1:0]                  prod;
   logic [SW_W-1:0]                    sw_pow, sw_init;
   logic [DIM_W-1:0]                   q_align;

   // request checks, format first
   always_comb begin
      if (!lmcl_pkg::fmt_supported(format_code)) begin
         chk_status = lmcl_pkg::STATUS_BAD_FORMAT;
      end else if (image_width == '0 || image_height == '0 ||
                   image_width > lmcl_pkg::IMG_DIM_W'(MAX_DIM) ||
                   image_height > lmcl_pkg::IMG_DIM_W'(MAX_DIM) ||
                   level_count == '0 ||
                   level_count > lmcl_pkg::LVL_W'(MAX_LEVELS)) begin
         chk_status = lmcl_pkg::STATUS_BAD_SIZE;
      end else begin
         chk_status = lmcl_pkg::STATUS_OK;
      end
   end

   // width quotient by the stride alignment, exact for all legal widths
   assign prod = PROD_W'(image_width[DIM_W-1:0]) * PROD_W'(RECIP);

   // storage width: the width rounded up to a power of two, never below the alignment
   always_comb begin
      sw_pow  = SW_W'(1) << lmcl_pkg::log2_ceil16(image_width);
      sw_init = (sw_pow < SW_W'(STRIDE_ALIGN)) ? SW_W'(STRIDE_ALIGN) : sw_pow;
   end

   // one-cycle pulse toward the first cell
   assign valid_in = load;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         w_ff   <= image_width[DIM_W-1:0];
         h_ff   <= image_height[DIM_W-1:0];
         q_ff   <= DIM_W'(prod >> lmcl_pkg::RECIP_SHIFT);
         sw_ff  <= sw_init;
         shl_ff <= SHL_W'(lmcl_pkg::log2_ceil16(image_height));
         bpp_ff <= lmcl_pkg::bpp_shift(format_code);
         lvl_ff <= level_count;
      end
   end

   // remainder from the registered quotient
   assign q_align = DIM_W'(q_ff * DIM_W'(STRIDE_ALIGN));

   assign valid   = valid_ff;
   assign w_out   = w_ff;
   assign h_out   = h_ff;
   assign q_out   = q_ff;
   assign r_out   = R_W'(w_ff - q_align);
   assign sw_out  = sw_ff;
   assign shl_out = shl_ff;
   assign bpp_out = bpp_ff;
   assign lvl_out = lvl_ff;

endmodule

`default_nettype wire

[hw/rtl/lmcl_cell.sv]
// one mip level cell: forms this level's result and the next level's state
// and hands that state to its neighbor; depends on lmcl_pkg
`default_nettype none

module lmcl_cell #(
   parameter int CELL_INDEX   = 0,
   parameter int MAX_DIM      = 4096,
   parameter int STRIDE_ALIGN = 8,
   localparam int DIM_W   = lmcl_pkg::dim_w(MAX_DIM),
   localparam int SW_W    = lmcl_pkg::sw_w(MAX_DIM, STRIDE_ALIGN),
   localparam int SHL_W   = lmcl_pkg::shl_w(MAX_DIM),
   localparam int SHA_W   = lmcl_pkg::sha_w(MAX_DIM),
   localparam int R_W     = lmcl_pkg::rem_w(STRIDE_ALIGN),
   localparam int PITCH_W = lmcl_pkg::pitch_w(MAX_DIM),
   localparam int TOT_W   = lmcl_pkg::tot_w(MAX_DIM, STRIDE_ALIGN)
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         adv,
   input  wire logic                         load,
   input  wire logic [DIM_W-1:0]             w_load,
   input  wire logic [DIM_W-1:0]             h_load,
   input  wire logic [DIM_W-1:0]             q_load,
   input  wire logic [R_W-1:0]               r_load,
   input  wire logic [SW_W-1:0]              sw_load,
   input  wire logic [SHL_W-1:0]             shl_load,
   input  wire logic [1:0]                   bpp_load,
   input  wire logic [lmcl_pkg::LVL_W-1:0]   lvl_load,
   input  wire logic [TOT_W-1:0]             total_load,
   output logic                              valid,
   output logic                              pass_valid,
   output logic [DIM_W-1:0]                  w_next,
   output logic [DIM_W-1:0]                  h_next,
   output logic [DIM_W-1:0]                  q_next,
   output logic [R_W-1:0]                    r_next,
   output logic [SW_W-1:0]                   sw_next,
   output logic [SHL_W-1:0]                  shl_next,
   output logic [1:0]                        bpp_next,
   output logic [lmcl_pkg::LVL_W-1:0]        lvl_next,
   output logic [TOT_W-1:0]                  total_next,
   output lmcl_pkg::result_type              result
);

   localparam int SAT_W = lmcl_pkg::SAT_IN_W;
   localparam int R1_W  = R_W + 1;

   logic                          valid_ff, valid_in;
   logic [DIM_W-1:0]              w_ff, h_ff, q_ff;
   logic [R_W-1:0]                r_ff;
   logic [SW_W-1:0]               sw_ff;
   logic [SHL_W-1:0]              shl_ff;
   logic [1:0]                    bpp_ff;
   logic [lmcl_pkg::LVL_W-1:0]    lvl_ff;
   logic [TOT_W-1:0]              total_ff;

   logic                          is_last;
   logic [DIM_W:0]                round_q;
   logic [PITCH_W-1:0]            pitch_full;
   logic [SHA_W-1:0]              sha;
   logic [TOT_W-1:0]              size_last, size_full;
   logic [DIM_W-1:0]              w_half, h_half, q_half;
   logic [R1_W-1:0]               r_sum;
   logic [R_W-1:0]                r_half;
   logic [SW_W-1:0]               sw_half;
   lmcl_pkg::result_type          res;

   // token hold: loads from the left, leaves once the output stage takes it
   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (valid_ff && adv) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         w_ff     <= w_load;
         h_ff     <= h_load;
         q_ff     <= q_load;
         r_ff     <= r_load;
         sw_ff    <= sw_load;
         shl_ff   <= shl_load;
         bpp_ff   <= bpp_load;
         lvl_ff   <= lvl_load;
         total_ff <= total_load;
      end
   end

   assign is_last = (lvl_ff == lmcl_pkg::LVL_W'(CELL_INDEX + 1));

   // row pitch and level footprint
   always_comb begin
      round_q    = {1'b0, q_ff} + (DIM_W + 1)'(|r_ff);
      pitch_full = PITCH_W'(PITCH_W'(round_q) * PITCH_W'(STRIDE_ALIGN)) << bpp_ff;
      sha        = SHA_W'(shl_ff) + SHA_W'(bpp_ff);
      size_last  = TOT_W'(pitch_full) * TOT_W'(h_ff);
      size_full  = TOT_W'(sw_ff) << sha;
      total_next = total_ff + (is_last ? size_last : size_full);
   end

   // halved dimensions for the neighbor, floored at one texel
   always_comb begin
      w_half  = w_ff >> 1;
      h_half  = h_ff >> 1;
      w_next  = (w_half == '0) ? DIM_W'(1) : w_half;
      h_next  = (h_half == '0) ? DIM_W'(1) : h_half;
      q_half  = q_ff >> 1;
      r_sum   = q_ff[0] ? (R1_W'(STRIDE_ALIGN) + R1_W'(r_ff)) : R1_W'(r_ff);
      r_half  = R_W'(r_sum >> 1);
      if (q_half == '0 && r_half == '0) begin
         q_next = DIM_W'(STRIDE_ALIGN == 1);
         r_next = R_W'(STRIDE_ALIGN != 1);
      end else begin
         q_next = q_half;
         r_next = r_half;
      end
      sw_half  = sw_ff >> 1;
      sw_next  = (sw_half > SW_W'(STRIDE_ALIGN)) ? sw_half : SW_W'(STRIDE_ALIGN);
      shl_next = (shl_ff == '0) ? '0 : shl_ff - SHL_W'(1);
      bpp_next = bpp_ff;
      lvl_next = lvl_ff;
   end

   // this level's result, zero when the cell is empty
   always_comb begin
      res.status       = lmcl_pkg::STATUS_OK;
      res.level_offset = lmcl_pkg::sat_size(SAT_W'(total_ff));
      res.level_pitch  = lmcl_pkg::sat_pitch(SAT_W'(pitch_full));
      res.tex_width    = lmcl_pkg::sat_dim(SAT_W'(w_ff));
      res.tex_height   = lmcl_pkg::sat_dim(SAT_W'(h_ff));
      res.run_total    = lmcl_pkg::sat_size(SAT_W'(total_next));
      res.last         = is_last;
      result           = valid_ff ? res : '0;
   end

   assign valid      = valid_ff;
   assign pass_valid = valid_ff && adv && !is_last;

endmodule

`default_nettype wire
